@@ rtl/core/mbrfb_pkg.sv @@
// Package with the types, constants and CRC function of the Modbus RTU frame builder.
`timescale 1ns / 1ps

package mbrfb_pkg;

	localparam logic [7:0]  MAX_REGISTERS = 8'd127;
	localparam logic [15:0] CRC_START     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [7:0]  FC_SINGLE     = 8'h06;
	localparam logic [7:0]  FC_MULTI      = 8'h10;

	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	localparam logic [1:0] KIND_MASTER_READ  = 2'd0;
	localparam logic [1:0] KIND_MASTER_WRITE = 2'd1;
	localparam logic [1:0] KIND_SLAVE_READ   = 2'd2;
	localparam logic [1:0] KIND_SLAVE_WRITE  = 2'd3;

	localparam int HDR_BYTES = 7;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  frame_kind;
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] register_address;
		logic [6:0]  register_count;
		logic [7:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
		logic       rejected;
	} out_item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/mbrfb_in_if.sv @@
// Valid/ready channel that carries request items into the frame builder.
`timescale 1ns / 1ps

interface mbrfb_in_if;
	import mbrfb_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mbrfb_out_if.sv @@
// Valid/ready channel that carries frame bytes out of the frame builder.
`timescale 1ns / 1ps

interface mbrfb_out_if;
	import mbrfb_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/modbus_rtu_frame_builder.sv @@
// Modbus RTU frame builder: header decode, payload tracking, byte emitter and running CRC-16.
// Latency: the first byte of an item is offered in the cycle after the transaction is taken.
// Throughput: one output byte per cycle while out_ch is ready; a header yields one to nine bytes, a payload byte one
// or three (with the CRC), an ignored payload byte none, all set by the single output port.
// The next item is taken in the cycle in which the last byte of the previous one leaves.
// Reset: asynchronous; it closes any open frame, empties the emitter and loads the CRC 0xFFFF.
`timescale 1ns / 1ps

module modbus_rtu_frame_builder
	import mbrfb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mbrfb_in_if.sink     in_ch,
	mbrfb_out_if.source  out_ch
);

	logic [7:0]  pend_bytes_q [HDR_BYTES];
	logic [2:0]  pend_n_q;
	logic        pend_crc_q;
	logic        pend_fresh_q;
	logic        pend_err_q;
	logic        pend_v_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        open_q;
	logic [7:0]  left_q;

	logic [7:0]  new_bytes [HDR_BYTES];
	logic [2:0]  new_n;
	logic        new_crc;
	logic        new_fresh;
	logic        new_err;
	logic        new_v;
	logic        new_open;
	logic [7:0]  new_left;
	logic [7:0]  need;
	logic [7:0]  bc;
	logic [7:0]  left_dec;

	logic [3:0]  total;
	logic        is_last;
	logic        is_data;
	logic        is_crc_hi;
	logic        fire;
	logic        take;
	logic [7:0]  cur_byte;
	logic [15:0] crc_base;

	in_item_t    it;

	assign it = in_ch.data;
	assign bc = {it.register_count, 1'b0};
	assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

	always_comb begin
		for (int i = 0; i < HDR_BYTES; i++) begin
			new_bytes[i] = 8'h00;
		end
		new_n     = 3'd0;
		new_crc   = 1'b0;
		new_fresh = 1'b0;
		new_err   = 1'b0;
		new_v     = 1'b0;
		new_open  = open_q;
		new_left  = left_q;
		need      = 8'd0;
		if (it.req_type == REQ_PAYLOAD) begin
			if (open_q) begin
				new_v        = 1'b1;
				new_bytes[0] = it.payload_byte;
				new_n        = 3'd1;
				new_left     = left_dec;
				if (left_dec == 8'd0) begin
					new_crc  = 1'b1;
					new_open = 1'b0;
				end
			end
		end else begin
			new_v     = 1'b1;
			new_fresh = 1'b1;
			new_open  = 1'b0;
			new_left  = 8'd0;
			if (({1'b0, it.register_count} > MAX_REGISTERS) ||
			    (((it.frame_kind == KIND_MASTER_WRITE) || (it.frame_kind == KIND_SLAVE_WRITE)) &&
			     (it.function_code == FC_SINGLE) && (it.register_count != 7'd1))) begin
				new_err = 1'b1;
			end else begin
				new_bytes[0] = it.slave_address;
				new_bytes[1] = it.function_code;
				if (it.frame_kind == KIND_SLAVE_READ) begin
					new_bytes[2] = bc;
					new_n        = 3'd3;
					need         = bc;
				end else begin
					new_bytes[2] = it.register_address[15:8];
					new_bytes[3] = it.register_address[7:0];
					new_n        = 3'd4;
					if (it.frame_kind == KIND_MASTER_READ) begin
						new_bytes[4] = 8'h00;
						new_bytes[5] = {1'b0, it.register_count};
						new_n        = 3'd6;
					end else if (it.function_code == FC_MULTI) begin
						new_bytes[4] = 8'h00;
						new_bytes[5] = {1'b0, it.register_count};
						new_bytes[6] = bc;
						new_n        = 3'd7;
						need         = (it.frame_kind == KIND_MASTER_WRITE) ? bc : 8'd0;
					end else if ((it.frame_kind == KIND_MASTER_WRITE) ||
					             (it.function_code == FC_SINGLE)) begin
						need = bc;
					end
				end
				if (need != 8'd0) begin
					new_open = 1'b1;
					new_left = need;
				end else begin
					new_crc = 1'b1;
				end
			end
		end
	end

	assign total     = pend_err_q ? 4'd1 : ({1'b0, pend_n_q} + (pend_crc_q ? 4'd2 : 4'd0));
	assign is_last   = (idx_q == total - 4'd1);
	assign is_data   = !pend_err_q && (idx_q < {1'b0, pend_n_q});
	assign is_crc_hi = !pend_err_q && !is_data && (idx_q != {1'b0, pend_n_q});
	assign cur_byte  = pend_bytes_q[idx_q[2:0]];
	assign crc_base  = (pend_fresh_q && (idx_q == 4'd0)) ? CRC_START : crc_q;

	assign fire = pend_v_q && out_ch.ready;
	assign in_ch.ready = !pend_v_q || (out_ch.ready && is_last);
	assign take = in_ch.valid && in_ch.ready;

	always_comb begin
		out_ch.valid = pend_v_q;
		if (pend_err_q) begin
			out_ch.data = '{frame_byte: 8'h00, last_byte: 1'b1, rejected: 1'b1};
		end else if (is_data) begin
			out_ch.data = '{frame_byte: cur_byte, last_byte: 1'b0, rejected: 1'b0};
		end else if (is_crc_hi) begin
			out_ch.data = '{frame_byte: crc_q[15:8], last_byte: 1'b1, rejected: 1'b0};
		end else begin
			out_ch.data = '{frame_byte: crc_q[7:0], last_byte: 1'b0, rejected: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			idx_q    <= 4'd0;
			crc_q    <= CRC_START;
			open_q   <= 1'b0;
			left_q   <= 8'd0;
		end else begin
			if (fire && is_data) begin
				crc_q <= crc_byte(crc_base, cur_byte);
			end else if (fire && is_crc_hi) begin
				crc_q <= CRC_START;
			end
			if (take) begin
				open_q   <= new_open;
				left_q   <= new_left;
				pend_v_q <= new_v;
				idx_q    <= 4'd0;
			end else if (fire) begin
				if (is_last) begin
					pend_v_q <= 1'b0;
					idx_q    <= 4'd0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && new_v) begin
			pend_bytes_q <= new_bytes;
			pend_n_q     <= new_n;
			pend_crc_q   <= new_crc;
			pend_fresh_q <= new_fresh;
			pend_err_q   <= new_err;
		end
	end

endmodule

@@ dv/tb.sv @@
// Testbench for the Modbus RTU frame builder: queued driver, byte monitor and CRC-16 predictor.
`timescale 1ns / 1ps

module tb;
	import mbrfb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 70;

	logic clk;
	logic arst_n;

	mbrfb_in_if  in_if ();
	mbrfb_out_if out_if ();

	modbus_rtu_frame_builder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	in_item_t    pending_items[$];
	out_item_t   expected_bytes[$];

	logic [15:0] model_crc;
	logic [7:0]  model_left;
	logic        model_open;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int cycle_count;
	int frames_started;
	int bytes_checked;
	int rejects_seen;

	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Returns the number of payload bytes a header asks for, or -1 when it is rejected.
	function automatic int payload_need(input in_item_t h);
		logic [7:0] bc;
		bc = {h.register_count, 1'b0};
		if ({1'b0, h.register_count} > MAX_REGISTERS ||
		    ((h.frame_kind == KIND_MASTER_WRITE || h.frame_kind == KIND_SLAVE_WRITE) &&
		     h.function_code == FC_SINGLE && h.register_count != 7'd1)) begin
			return -1;
		end
		case (h.frame_kind)
			KIND_MASTER_READ: return 0;
			KIND_MASTER_WRITE: return int'(bc);
			KIND_SLAVE_READ: return int'(bc);
			default: return (h.function_code == FC_SINGLE) ? int'(bc) : 0;
		endcase
	endfunction

	function automatic in_item_t make_header(input logic [1:0] kind, input logic [7:0] addr,
		input logic [7:0] fc, input logic [15:0] reg_addr, input logic [6:0] cnt);
		in_item_t it;
		it.req_type         = REQ_HEADER;
		it.frame_kind       = kind;
		it.slave_address    = addr;
		it.function_code    = fc;
		it.register_address = reg_addr;
		it.register_count   = cnt;
		it.payload_byte     = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_payload(input logic [7:0] b);
		in_item_t it;
		it.req_type         = REQ_PAYLOAD;
		it.frame_kind       = 2'($urandom);
		it.slave_address    = 8'($urandom);
		it.function_code    = 8'($urandom);
		it.register_address = 16'($urandom);
		it.register_count   = 7'($urandom);
		it.payload_byte     = b;
		return it;
	endfunction

	task automatic emit_byte(input logic [7:0] b);
		out_item_t o;
		o.frame_byte = b;
		o.last_byte  = 1'b0;
		o.rejected   = 1'b0;
		model_crc = crc16_fold(model_crc, b);
		expected_bytes.push_back(o);
	endtask

	task automatic emit_crc();
		out_item_t o;
		o.frame_byte = model_crc[7:0];
		o.last_byte  = 1'b0;
		o.rejected   = 1'b0;
		expected_bytes.push_back(o);
		o.frame_byte = model_crc[15:8];
		o.last_byte  = 1'b1;
		expected_bytes.push_back(o);
		model_crc  = CRC_START;
		model_open = 1'b0;
		model_left = 8'd0;
	endtask

	task automatic predict_frame_bytes(input in_item_t it);
		int         need;
		logic [7:0] bc;
		out_item_t  err;
		if (it.req_type == REQ_PAYLOAD) begin
			if (model_open) begin
				emit_byte(it.payload_byte);
				if (model_left > 0) begin
					model_left--;
				end
				if (model_left == 0) begin
					emit_crc();
				end
			end
		end else begin
			model_open = 1'b0;
			model_left = 8'd0;
			model_crc  = CRC_START;
			frames_started++;
			need = payload_need(it);
			bc   = {it.register_count, 1'b0};
			if (need < 0) begin
				err.frame_byte = 8'd0;
				err.last_byte  = 1'b1;
				err.rejected   = 1'b1;
				expected_bytes.push_back(err);
			end else begin
				emit_byte(it.slave_address);
				emit_byte(it.function_code);
				if (it.frame_kind == KIND_SLAVE_READ) begin
					emit_byte(bc);
				end else begin
					emit_byte(it.register_address[15:8]);
					emit_byte(it.register_address[7:0]);
					if (it.frame_kind == KIND_MASTER_READ || it.function_code == FC_MULTI) begin
						emit_byte(8'd0);
						emit_byte({1'b0, it.register_count});
						if (it.frame_kind != KIND_MASTER_READ) begin
							emit_byte(bc);
						end
					end
				end
				if (need > 0) begin
					model_left = 8'(need);
					model_open = 1'b1;
				end else begin
					emit_crc();
				end
			end
		end
	endtask

	task automatic load_directed();
		pending_items.push_back(make_header(KIND_MASTER_READ, 8'h00, 8'h03, 16'h0000, 7'd0));
		pending_items.push_back(make_header(KIND_MASTER_READ, 8'hFF, 8'hFF, 16'hFFFF, 7'd127));
		pending_items.push_back(make_header(KIND_MASTER_WRITE, 8'h11, FC_SINGLE, 16'h1234, 7'd1));
		pending_items.push_back(make_payload(8'h00));
		pending_items.push_back(make_payload(8'hFF));
		pending_items.push_back(make_header(KIND_MASTER_WRITE, 8'h01, FC_SINGLE, 16'h0001, 7'd0));
		pending_items.push_back(make_header(KIND_SLAVE_WRITE, 8'h02, FC_SINGLE, 16'h0002, 7'd5));
		pending_items.push_back(make_header(KIND_SLAVE_READ, 8'h0A, 8'h03, 16'hBEEF, 7'd1));
		pending_items.push_back(make_payload(8'hA5));
		pending_items.push_back(make_payload(8'h5A));
		pending_items.push_back(make_header(KIND_SLAVE_READ, 8'h0B, 8'h04, 16'h0000, 7'd0));
		pending_items.push_back(make_header(KIND_SLAVE_WRITE, 8'h7F, FC_MULTI, 16'h8000, 7'd127));
		pending_items.push_back(make_header(KIND_SLAVE_WRITE, 8'h80, FC_SINGLE, 16'h00FF, 7'd1));
		pending_items.push_back(make_payload(8'h12));
		pending_items.push_back(make_payload(8'h34));
		pending_items.push_back(make_header(KIND_SLAVE_WRITE, 8'h33, 8'h05, 16'h0F0F, 7'd3));
		pending_items.push_back(make_header(KIND_MASTER_WRITE, 8'h44, 8'h0F, 16'hF0F0, 7'd1));
		pending_items.push_back(make_payload(8'h55));
		pending_items.push_back(make_payload(8'hAA));
		// A stray payload byte with no frame open must be dropped silently.
		pending_items.push_back(make_payload(8'hC3));
		// A frame cut short by a new header is abandoned without its CRC.
		pending_items.push_back(make_header(KIND_MASTER_WRITE, 8'h21, FC_MULTI, 16'h0102, 7'd2));
		pending_items.push_back(make_payload(8'h99));
		pending_items.push_back(make_header(KIND_SLAVE_READ, 8'h22, 8'h03, 16'h0304, 7'd0));
		pending_items.push_back(make_header(KIND_MASTER_WRITE, 8'h23, FC_MULTI, 16'h0506, 7'd0));
	endtask

	task automatic load_random_frames(input int target);
		int        counted;
		int        need;
		int        sent_bytes;
		int        pick;
		logic      left_open;
		logic [7:0] fc;
		logic [6:0] cnt;
		counted   = 0;
		left_open = 1'b0;
		while (counted < target) begin
			if (!left_open && $urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 3)) pending_items.push_back(make_payload(8'($urandom)));
			end
			pick = $urandom_range(9);
			if (pick < 4) begin
				fc = FC_MULTI;
			end else if (pick < 7) begin
				fc = FC_SINGLE;
			end else begin
				fc = 8'($urandom);
			end
			if (fc == FC_SINGLE) begin
				cnt = ($urandom_range(99) < 80) ? 7'd1 : 7'($urandom_range(0, 7));
			end else if ($urandom_range(99) < 6) begin
				cnt = 7'($urandom_range(0, 127));
			end else begin
				cnt = 7'($urandom_range(0, 4));
			end
			pending_items.push_back(make_header(2'($urandom), 8'($urandom), fc,
				16'($urandom), cnt));
			counted++;
			need      = payload_need(pending_items[$]);
			left_open = 1'b0;
			if (need > 0) begin
				sent_bytes = need;
				if ($urandom_range(99) < 15) begin
					sent_bytes = $urandom_range(0, need - 1);
					left_open  = 1'b1;
				end
				if (sent_bytes > target - counted) begin
					sent_bytes = target - counted;
					left_open  = 1'b1;
				end
				repeat (sent_bytes) pending_items.push_back(make_payload(8'($urandom)));
				counted += sent_bytes;
			end
		end
	endtask

	task automatic wait_for_drain();
		while (pending_items.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n        = 1'b0;
		in_if.valid   = 1'b0;
		in_if.data    = '0;
		out_if.ready  = 1'b0;
		model_crc     = CRC_START;
		model_left    = 8'd0;
		model_open    = 1'b0;
		fail_count    = 0;
		frames_started = 0;
		bytes_checked = 0;
		rejects_seen  = 0;
		send_idle_pct = 11;
		recv_idle_pct = 50;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		load_directed();
		load_random_frames(PHASE_ITEMS);
		wait_for_drain();
		send_idle_pct = 50;
		recv_idle_pct = 11;
		load_random_frames(PHASE_ITEMS);
		wait_for_drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_random_frames(PHASE_ITEMS);

		while (pending_items.size() != 0 || in_if.valid || expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d headers, including %0d rejected ones, across three idling phases.",
			frames_started, rejects_seen);
		$display("Checked %0d frame bytes against the predicted CRC-16 stream.", bytes_checked);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles.", cycle_count);
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				predict_frame_bytes(in_if.data);
			end
			if (!in_if.valid || in_if.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_if.valid <= 1'b1;
					in_if.data  <= pending_items.pop_front();
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_bytes.size() == 0) begin
				$error("Output transaction with no expected byte: frame_byte %02h",
					out_if.data.frame_byte);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (want.rejected) begin
					rejects_seen++;
				end
				if (out_if.data.frame_byte !== want.frame_byte) begin
					$error("frame_byte mismatch: expected %02h, actual %02h",
						want.frame_byte, out_if.data.frame_byte);
					fail_count++;
				end
				if (out_if.data.last_byte !== want.last_byte) begin
					$error("last_byte mismatch: expected %0b, actual %0b",
						want.last_byte, out_if.data.last_byte);
					fail_count++;
				end
				if (out_if.data.rejected !== want.rejected) begin
					$error("rejected mismatch: expected %0b, actual %0b",
						want.rejected, out_if.data.rejected);
					fail_count++;
				end
			end
		end
	end

endmodule

@@ files.f @@
rtl/core/mbrfb_pkg.sv
rtl/core/mbrfb_in_if.sv
rtl/core/mbrfb_out_if.sv
rtl/core/modbus_rtu_frame_builder.sv
dv/tb.sv
